@@ sv/flpw_pkg.sv @@
// flpw_pkg: shared types and constants for the four-level page walk block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package flpw_pkg;
   localparam int unsigned ADDR_W   = 48;
   localparam int unsigned DATA_W   = 64;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned IDX_W    = 9;
   localparam int unsigned OFF_W    = 12;
   localparam int unsigned LEVELS   = 4;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAULT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUST = 2'd2;

   typedef struct packed {
      logic                func;
      logic [ADDR_W-1:0]   virt_addr;
      logic [3:0]          size;
      logic [DATA_W-1:0]   write_data;
      logic                make;
   } cmd_type;
endpackage
`default_nettype wire

@@ sv/flpw_front.sv @@
// flpw_front: accepts requests, clamps size, qualifies create, two-entry queue
// depends on flpw_pkg
`timescale 1ns / 1ps
`default_nettype none
module flpw_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire                   req_func,
   input  wire [47:0]            req_virt_addr,
   input  wire [3:0]             req_size,
   input  wire [63:0]            req_write_data,
   input  wire                   req_create,
   output logic                  q_valid,
   output flpw_pkg::cmd_type     q_cmd,
   input  wire                   q_take,
   input  wire                   back_idle
);
   import flpw_pkg::*;

   cmd_type   slot_ff [2];
   cmd_type   slot_in;
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;

   // sequential: one item in the block at a time
   assign busy    = (count_ff != 2'd0) || !back_idle;
   assign push    = start && !busy;
   assign q_valid = count_ff != 2'd0;
   assign q_cmd   = slot_ff[rd_ff];

   always_comb begin
      slot_in.func       = req_func;
      slot_in.virt_addr  = req_virt_addr;
      slot_in.size       = (req_size > 4'd8) ? 4'd8 : req_size;
      slot_in.write_data = req_write_data;
      slot_in.make       = req_func && req_create;
      count_in = count_ff + {1'b0, push} - {1'b0, q_take};
      rd_in    = rd_ff ^ q_take;
      wr_in    = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= slot_in;
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(count_ff == 2'd2 && push && !q_take)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_take |-> count_ff != 2'd0) else $error("queue underflow");
   a_busy_when_held: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> busy) else $error("busy low with queued item");
endmodule
`default_nettype wire

@@ sv/flpw_back.sv @@
// flpw_back: walks the table per byte and moves bytes into or out of pages
// depends on flpw_pkg; holds link and page memories plus clearing pass
`timescale 1ns / 1ps
`default_nettype none
module flpw_back #(
   parameter int unsigned NODE_COUNT = 64,
   parameter int unsigned PAGE_COUNT = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_valid,
   input  flpw_pkg::cmd_type     q_cmd,
   output logic                  q_take,
   output logic                  idle,
   output logic                  rsp_valid,
   output logic [63:0]           rsp_read_data,
   output logic [1:0]            rsp_status
);
   import flpw_pkg::*;

   localparam int unsigned NODE_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int unsigned PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int unsigned LINK_W  = (NODE_W > PAGE_W) ? NODE_W : PAGE_W;
   localparam int unsigned NFREE_W = $clog2(NODE_COUNT + 1);
   localparam int unsigned PFREE_W = $clog2(PAGE_COUNT + 1);
   localparam int unsigned LA_W    = NODE_W + IDX_W;
   localparam int unsigned PA_W    = PAGE_W + OFF_W;
   localparam int unsigned LDEPTH  = NODE_COUNT * 512;
   localparam int unsigned PDEPTH  = PAGE_COUNT * 4096;
   localparam int unsigned CLR_W   = (PA_W > LA_W) ? PA_W + 1 : LA_W + 1;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_LREAD = 7'b0000100,
      S_LWAIT = 7'b0001000,
      S_LEVAL = 7'b0010000,
      S_PACC  = 7'b0100000,
      S_PWAIT = 7'b1000000
   } state_type;

   logic [LINK_W:0] link_mem [LDEPTH];
   logic [7:0]      page_mem [PDEPTH];

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [3:0]       byte_ff, byte_in;
   logic [1:0]       lvl_ff, lvl_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [NFREE_W-1:0] nfree_ff, nfree_in;
   logic [PFREE_W-1:0] pfree_ff, pfree_in;
   logic [63:0]      rdata_ff, rdata_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [LINK_W:0]  link_q;
   logic [7:0]       page_q;
   logic             done_ff, done_in;
   logic [1:0]       stat_ff, stat_in;

   logic [ADDR_W-1:0] baddr;
   logic [IDX_W-1:0]  eidx;
   logic [LA_W-1:0]   laddr;
   logic [PA_W-1:0]   paddr;
   logic              lwe, pwe;
   logic [LINK_W:0]   lwdata;
   logic [7:0]        pwdata;
   logic [LINK_W-1:0] link_idx;
   logic [PAGE_W-1:0] page_ff, page_in;

   always_comb begin
      baddr = q_cmd.virt_addr;
      baddr = cmd_ff.virt_addr + ADDR_W'(byte_ff);
      case (lvl_ff)
         2'd0:    eidx = baddr[47:39];
         2'd1:    eidx = baddr[38:30];
         2'd2:    eidx = baddr[29:21];
         default: eidx = baddr[20:12];
      endcase
   end

   assign q_take = (state_ff == S_IDLE) && q_valid;
   assign idle   = (state_ff == S_IDLE) && !done_ff;
   assign link_idx = link_q[LINK_W-1:0];

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      byte_in  = byte_ff;
      lvl_in   = lvl_ff;
      node_in  = node_ff;
      page_in  = page_ff;
      nfree_in = nfree_ff;
      pfree_in = pfree_ff;
      rdata_in = rdata_ff;
      clr_in   = clr_ff;
      done_in  = 1'b0;
      stat_in  = stat_ff;
      lwe      = 1'b0;
      pwe      = 1'b0;
      lwdata   = '0;
      pwdata   = '0;
      laddr    = {node_ff, eidx};
      paddr    = {page_ff, baddr[OFF_W-1:0]};
      case (state_ff)
         S_CLEAR: begin
            // clears one link entry and one page byte per cycle, each until its own memory ends
            lwe   = clr_ff < CLR_W'(LDEPTH);
            pwe   = 1'b1;
            laddr = clr_ff[LA_W-1:0];
            paddr = clr_ff[PA_W-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(((PDEPTH > LDEPTH) ? PDEPTH : LDEPTH) - 1))
               state_in = S_IDLE;
            if (clr_ff >= CLR_W'(PDEPTH)) pwe = 1'b0;
         end
         S_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_cmd;
               byte_in  = '0;
               lvl_in   = '0;
               node_in  = '0;
               rdata_in = '0;
               stat_in  = STATUS_OK;
               if (q_cmd.size == 4'd0) done_in = 1'b1;
               else state_in = S_LREAD;
            end
         end
         S_LREAD: state_in = S_LWAIT;
         S_LWAIT: state_in = S_LEVAL;
         S_LEVAL: begin
            if (!link_q[LINK_W]) begin
               if (!cmd_ff.make) begin
                  stat_in = STATUS_FAULT; done_in = 1'b1; state_in = S_IDLE;
               end else if (lvl_ff != 2'd3) begin
                  if (nfree_ff >= NFREE_W'(NODE_COUNT)) begin
                     stat_in = STATUS_EXHAUST; done_in = 1'b1; state_in = S_IDLE;
                  end else begin
                     lwe      = 1'b1;
                     lwdata   = {1'b1, LINK_W'(nfree_ff)};
                     node_in  = NODE_W'(nfree_ff);
                     nfree_in = nfree_ff + 1'b1;
                     lvl_in   = lvl_ff + 1'b1;
                     state_in = S_LREAD;
                  end
               end else begin
                  if (pfree_ff >= PFREE_W'(PAGE_COUNT)) begin
                     stat_in = STATUS_EXHAUST; done_in = 1'b1; state_in = S_IDLE;
                  end else begin
                     lwe      = 1'b1;
                     lwdata   = {1'b1, LINK_W'(pfree_ff)};
                     page_in  = PAGE_W'(pfree_ff);
                     pfree_in = pfree_ff + 1'b1;
                     state_in = S_PACC;
                  end
               end
            end else if (lvl_ff != 2'd3) begin
               node_in  = NODE_W'(link_idx);
               lvl_in   = lvl_ff + 1'b1;
               state_in = S_LREAD;
            end else begin
               page_in  = PAGE_W'(link_idx);
               state_in = S_PACC;
            end
         end
         S_PACC: begin
            if (cmd_ff.func) begin
               pwe    = 1'b1;
               pwdata = cmd_ff.write_data[8*byte_ff[2:0] +: 8];
            end
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (!cmd_ff.func) rdata_in[8*byte_ff[2:0] +: 8] = page_q;
            lvl_in  = '0;
            node_in = '0;
            byte_in = byte_ff + 1'b1;
            if (byte_ff + 1'b1 == cmd_ff.size) begin
               done_in = 1'b1; state_in = S_IDLE;
            end else state_in = S_LREAD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memories: registered read, one port each
   always_ff @(posedge clock) begin
      if (lwe) link_mem[laddr] <= lwdata;
      link_q <= link_mem[laddr];
      if (pwe) page_mem[paddr] <= pwdata;
      page_q <= page_mem[paddr];
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      byte_ff  <= byte_in;
      lvl_ff   <= lvl_in;
      node_ff  <= node_in;
      page_ff  <= page_in;
      rdata_ff <= rdata_in;
      stat_ff  <= stat_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         nfree_ff <= NFREE_W'(1);
         pfree_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         nfree_ff <= nfree_in;
         pfree_ff <= pfree_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid     = done_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_status    = stat_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      nfree_ff <= NFREE_W'(NODE_COUNT) && pfree_ff <= PFREE_W'(PAGE_COUNT))
      else $error("pool counter past end");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> !done_ff || state_ff == S_IDLE) else $error("take outside idle");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("result longer than one cycle");
endmodule
`default_nettype wire

@@ sv/four_level_page_walk_sparse_memory_top.sv @@
// channel   ports                                   handshake
// request   req_func req_virt_addr req_size ...     start & !busy
// response  rsp_read_data rsp_status                rsp_valid, one cycle
// an item is handled byte by byte: per byte, each table level walked takes a link read,
// wait and evaluate step, and the page byte, when it is reached, an access and wait step
// after reset a clearing pass zeroes every link entry and page byte, busy high
// results cannot be stalled; the next request is taken the cycle after the response
// depends on flpw_pkg, flpw_front, flpw_back
`timescale 1ns / 1ps
`default_nettype none
module four_level_page_walk_sparse_memory_top #(
   parameter int unsigned NODE_COUNT = 64,
   parameter int unsigned PAGE_COUNT = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_func,
   input  wire [47:0]  req_virt_addr,
   input  wire [3:0]   req_size,
   input  wire [63:0]  req_write_data,
   input  wire         req_create,
   output logic        rsp_valid,
   output logic [63:0] rsp_read_data,
   output logic [1:0]  rsp_status
);
   import flpw_pkg::*;

   cmd_type q_cmd;
   logic    q_valid, q_take, back_idle;

   flpw_front u_front (
      .clock, .reset, .start, .busy,
      .req_func, .req_virt_addr, .req_size, .req_write_data, .req_create,
      .q_valid, .q_cmd, .q_take, .back_idle
   );

   flpw_back #(.NODE_COUNT(NODE_COUNT), .PAGE_COUNT(PAGE_COUNT)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_take,
      .idle(back_idle), .rsp_valid, .rsp_read_data, .rsp_status
   );
endmodule
`default_nettype wire
